// ----- rtl/core/sleep_slot_countdown_timer_top_assert.svh -----
// ----------------------------------------------------------------------------
// Sleep slot countdown timer - assertion macros
// Shared concurrent assertion macros; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef SLEEP_SLOT_COUNTDOWN_TIMER_TOP_ASSERT_SVH
`define SLEEP_SLOT_COUNTDOWN_TIMER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define SSCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SSCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SSCT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ----- rtl/core/ssct_pkg.sv -----
// ----------------------------------------------------------------------------
// Sleep slot countdown timer - package
// Sizes, codes and the structs shared by the slot cells and the top level.
// ----------------------------------------------------------------------------
package ssct_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int RES_LIMIT = 8;   // wake results per tick, at most
    localparam int NWAKE_W   = 4;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_SLEEP = 1'b1;

    typedef enum logic [1:0] {
        KIND_WAKE  = 2'd0,
        KIND_SLEEP = 2'd1,
        KIND_YIELD = 2'd2
    } kind_e_t;

    typedef struct packed {
        logic        func;
        logic [15:0] requester_id;
        logic [30:0] sleep_ticks;
    } in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] wake_id;
        logic [2:0]  slot_index;
        logic [31:0] tick_count;
        logic        last;
    } out_t;

    // result raised by a cell, tick count added at the output stage
    typedef struct packed {
        logic        valid;
        kind_e_t     kind;
        logic [15:0] id;
        logic [2:0]  slot;
        logic        last;
    } res_t;

    // request token walking down the row of cells
    typedef struct packed {
        logic               valid;
        logic               func;
        logic [15:0]        id;
        logic [30:0]        ticks;
        logic               taken;
        logic [NWAKE_W-1:0] nwake;
        res_t               res;
    } tok_t;

    // status handed from the high end of the row towards cell 0
    typedef struct packed {
        logic busy;
        logic later_wake;
        res_t res;
    } back_t;

    // slot number as carried in the 3-bit result field (wraps modulo 8)
    function automatic logic [2:0] slot_field(input logic [SLOT_W-1:0] idx);
        logic [SLOT_W+2:0] wide;
        wide = {3'b000, idx};
        return wide[2:0];
    endfunction

endpackage

// ----- rtl/core/sleep_slot_countdown_timer_top.sv -----
// ----------------------------------------------------------------------------
// Sleep slot countdown timer - top level
// Countdown slot table for sleeping requesters, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Each accepted request enters cell 0 as a token and moves one cell per clock
// down the row of NUM_SLOTS slot cells, except while the row holds. The row
// reports busy until the token has left the last cell, so a new request is
// taken only after the previous token is through. The whole row holds while
// a cell holds a raised result and the output register is still full and not
// being drained. A tick increments the 32-bit tick counter on acceptance and
// decrements every busy slot as the token passes it; each slot reaching zero
// raises a wake result in slot order, the last one flagged, at most eight per
// tick. A sleep request claims the lowest free slot it passes; if none is free,
// or the count is zero, the last cell answers with a yield. tick_count in every
// result is the counter after the request. One output register parts the two
// sides; no clearing pass is needed after reset.
`include "sleep_slot_countdown_timer_top_assert.svh"

module sleep_slot_countdown_timer_top
    import ssct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  in_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output out_t out_data
);

    tok_t        tok  [0:NUM_SLOTS];
    back_t       back [0:NUM_SLOTS];
    logic        adv;
    logic        accept;
    logic [31:0] ticks_reg, ticks_next;
    logic        out_valid_reg, out_valid_next;
    out_t        out_reg, out_next;

    // idle once no token sits in any cell
    assign in_ready = !back[0].busy;
    assign accept   = in_valid && in_ready;

    // the row holds only when a result is waiting and the output is blocked
    assign adv = !(back[0].res.valid && out_valid_reg && !out_ready);

    always_comb
    begin
        tok[0]       = '0;
        tok[0].valid = accept;
        tok[0].func  = in_data.func;
        tok[0].id    = in_data.requester_id;
        tok[0].ticks = in_data.sleep_ticks;
    end

    assign back[NUM_SLOTS] = '0;

    for (genvar g = 0; g < NUM_SLOTS; g++)
    begin : g_cell
        ssct_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .idx      (SLOT_W'(g)),
            .adv      (adv),
            .tok_in   (tok[g]),
            .tok_out  (tok[g+1]),
            .back_in  (back[g+1]),
            .back_out (back[g])
        );
    end

    // tick counter advances as the tick request is taken
    always_comb
    begin
        ticks_next = ticks_reg;
        if (accept && in_data.func == FUNC_TICK)
        begin
            ticks_next = ticks_reg + 32'd1;
        end
    end

    // output register: loaded as the token carrying a result moves on
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (adv && back[0].res.valid)
        begin
            out_valid_next      = 1'b1;
            out_next.kind       = back[0].res.kind;
            out_next.wake_id    = back[0].res.id;
            out_next.slot_index = back[0].res.slot;
            out_next.tick_count = ticks_reg;
            out_next.last       = back[0].res.last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ticks_reg     <= ticks_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    `SSCT_ASSERT_IMP(a_idle_no_result, clk, rst_n, in_ready, !back[0].res.valid)
    `SSCT_ASSERT_NEXT(a_tick_advances, clk, rst_n, in_valid && in_ready && in_data.func == FUNC_TICK, ticks_reg == $past(ticks_reg) + 32'd1)
    `SSCT_ASSERT_IMP(a_tail_answers, clk, rst_n, tok[NUM_SLOTS].valid && tok[NUM_SLOTS].func == FUNC_SLEEP && !tok[NUM_SLOTS].taken, tok[NUM_SLOTS].res.valid)
    `SSCT_ASSERT_IMP(a_hold_only_when_full, clk, rst_n, !adv, out_valid_reg)

endmodule

// ----- rtl/core/ssct_cell.sv -----
// ----------------------------------------------------------------------------
// Sleep slot countdown timer - slot cell
// One countdown slot; serves the request token as it passes through.
// ----------------------------------------------------------------------------
`include "sleep_slot_countdown_timer_top_assert.svh"

module ssct_cell
    import ssct_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [SLOT_W-1:0] idx,
    input  logic              adv,
    input  tok_t              tok_in,
    output tok_t              tok_out,
    input  back_t             back_in,
    output back_t             back_out
);

    logic [30:0] count_reg, count_next;
    logic [15:0] owner_reg, owner_next;
    tok_t        tok_reg, tok_next;
    logic        tail;

    assign tail = (idx == SLOT_W'(NUM_SLOTS - 1));

    always_comb
    begin
        tok_next   = tok_in;
        tok_next.res = '0;
        count_next = count_reg;
        owner_next = owner_reg;
        if (tok_in.valid)
        begin
            case (tok_in.func)
                FUNC_TICK:
                begin
                    if (count_reg != '0)
                    begin
                        count_next = count_reg - 31'd1;
                        if (count_reg == 31'd1 && tok_in.nwake < NWAKE_W'(RES_LIMIT))
                        begin
                            tok_next.res.valid = 1'b1;
                            tok_next.res.kind  = KIND_WAKE;
                            tok_next.res.id    = owner_reg;
                            tok_next.res.slot  = slot_field(idx);
                            // final wake of this tick: none further down, or limit hit
                            tok_next.res.last  = !back_in.later_wake ||
                                (tok_in.nwake == NWAKE_W'(RES_LIMIT - 1));
                            tok_next.nwake     = tok_in.nwake + NWAKE_W'(1);
                        end
                    end
                end
                FUNC_SLEEP:
                begin
                    if (!tok_in.taken && count_reg == '0 && tok_in.ticks != '0)
                    begin
                        count_next         = tok_in.ticks;
                        owner_next         = tok_in.id;
                        tok_next.taken     = 1'b1;
                        tok_next.res.valid = 1'b1;
                        tok_next.res.kind  = KIND_SLEEP;
                        tok_next.res.id    = tok_in.id;
                        tok_next.res.slot  = slot_field(idx);
                        tok_next.res.last  = 1'b1;
                    end
                    else if (tail && !tok_in.taken)
                    begin
                        // no slot taken anywhere: answer yield
                        tok_next.res.valid = 1'b1;
                        tok_next.res.kind  = KIND_YIELD;
                        tok_next.res.id    = tok_in.id;
                        tok_next.res.slot  = 3'd0;
                        tok_next.res.last  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            count_reg <= count_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            owner_reg <= owner_next;
        end
    end

    assign tok_out             = tok_reg;
    assign back_out.busy       = back_in.busy | tok_reg.valid;
    assign back_out.later_wake = back_in.later_wake | (count_reg == 31'd1);
    assign back_out.res        = (tok_reg.valid && tok_reg.res.valid) ? tok_reg.res
                                                                      : back_in.res;

    `SSCT_ASSERT_IMP(a_sleep_holds_count, clk, rst_n, tok_reg.valid && tok_reg.res.valid && tok_reg.res.kind == KIND_SLEEP, count_reg != '0)
    `SSCT_ASSERT_IMP(a_wake_frees_slot, clk, rst_n, tok_reg.valid && tok_reg.res.valid && tok_reg.res.kind == KIND_WAKE, count_reg == '0)
    `SSCT_ASSERT_IMP(a_count_moves_with_token, clk, rst_n, !$stable(count_reg), $past(tok_in.valid && adv))

endmodule

// ----- tb/sv/tb_sleep_slot_countdown_timer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sleep slot countdown timer - testbench
// Drives tick and sleep requests into the slot table and checks every result.
// Each request is predicted on acceptance and checked field by field, in order.
// ----------------------------------------------------------------------------
// Flow: directed tests first (yields, empty-table ticks, a full table waking
// all at once, staggered wakes with slot reuse), then a long random run.
// Both sides idle at random, with stretches of no idling.
// Pressure: the result side is held off for a long stretch while requests keep
// coming, and the request side is paused once until everything has drained.
// The longest possible sleep is left until the end, as it holds its slot for
// good.
// ----------------------------------------------------------------------------
module tb_sleep_slot_countdown_timer_top;
    import ssct_pkg::*;

    localparam int CYCLE_LIMIT  = 400000; // far above the slowest correct run
    localparam int SETTLE_TAIL  = 64;     // covers a tick with no wakeups plus a stall
    localparam int LONG_HOLD    = 400;    // result side hold-off, in cycles
    localparam int RANDOM_ITEMS = 200;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_ready;
    in_t  in_data   = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    out_t out_data;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sleep_slot_countdown_timer_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // ------------------------------------------------------------------------
    // Predicted slot table: countdowns, owners and the running tick counter.
    // Owners are only ever read after a sleep has written them.
    // ------------------------------------------------------------------------
    logic [30:0] slot_left   [NUM_SLOTS] = '{default: '0};
    logic [15:0] slot_holder [NUM_SLOTS] = '{default: '0};
    logic [31:0] ticks_seen  = '0;

    out_t due_events[$];   // results still owed by the block, oldest first
    out_t next_due;
    int   fault_count = 0;
    int   cycle_count = 0;

    // idling controls, shared with the result sink
    bit source_idle      = 1'b1;
    bit sink_idle        = 1'b1;
    int sink_hold_cycles = 0;

    // Works out what one accepted request owes and queues it.
    function automatic void predict_slot_table(input in_t req);
        out_t ev;
        out_t wakes[$];
        bit   placed;
        placed = 1'b0;
        if (req.func == FUNC_SLEEP)
        begin
            // default answer: yield, counter untouched
            ev.kind       = KIND_YIELD;
            ev.wake_id    = req.requester_id;
            ev.slot_index = 3'd0;
            ev.tick_count = ticks_seen;
            ev.last       = 1'b1;
            if (req.sleep_ticks != '0)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!placed && slot_left[i] == '0)
                    begin
                        slot_left[i]   = req.sleep_ticks;
                        slot_holder[i] = req.requester_id;
                        ev.kind        = KIND_SLEEP;
                        ev.slot_index  = 3'(i);
                        placed         = 1'b1;
                    end
                end
            end
            due_events.push_back(ev);
        end
        else
        begin
            ticks_seen = ticks_seen + 32'd1;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (slot_left[i] != '0)
                begin
                    slot_left[i] = slot_left[i] - 31'd1;
                    // slot is freed regardless; only the first RES_LIMIT report
                    if (slot_left[i] == '0 && wakes.size() < RES_LIMIT)
                    begin
                        ev.kind       = KIND_WAKE;
                        ev.wake_id    = slot_holder[i];
                        ev.slot_index = 3'(i);
                        ev.tick_count = ticks_seen;
                        ev.last       = 1'b0;
                        wakes.push_back(ev);
                    end
                end
            end
            if (wakes.size() > 0)
                wakes[wakes.size()-1].last = 1'b1;
            foreach (wakes[k])
                due_events.push_back(wakes[k]);
        end
    endfunction

    function automatic int free_slot_total();
        int n;
        n = 0;
        foreach (slot_left[i])
            if (slot_left[i] == '0)
                n++;
        return n;
    endfunction

    function automatic in_t tick_request();
        in_t r;
        r              = '0;
        r.func         = FUNC_TICK;
        r.requester_id = 16'($urandom);   // ignored by a tick, but keep it moving
        r.sleep_ticks  = 31'($urandom);
        return r;
    endfunction

    function automatic in_t sleep_request(input logic [15:0] id, input logic [30:0] ticks);
        in_t r;
        r.func         = FUNC_SLEEP;
        r.requester_id = id;
        r.sleep_ticks  = ticks;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Valid is left high on return so a back-to-back request
    // needs no second assignment in the same step; settle_outputs lowers it.
    // ------------------------------------------------------------------------
    task automatic send_timer_request(input in_t req);
        int gap;
        gap = source_idle ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_slot_table(req);
    endtask

    // Stops offering requests and waits until every owed result has come back.
    // It always waits on the clock before checking, so valid is never driven twice
    // in one step.
    task automatic settle_outputs();
        in_valid <= 1'b0;
        @(posedge clk);
        while (due_events.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls per result, plus the long hold-off on demand.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (sink_hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (sink_hold_cycles) @(posedge clk);
                sink_hold_cycles = 0;
            end
            stall = sink_idle ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: each accepted result against the oldest prediction.
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            fault_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (due_events.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, out_data);
                fault_count++;
            end
            else
            begin
                next_due = due_events.pop_front();
                check_field("kind",       32'(next_due.kind),       32'(out_data.kind));
                check_field("wake_id",    32'(next_due.wake_id),    32'(out_data.wake_id));
                check_field("slot_index", 32'(next_due.slot_index), 32'(out_data.slot_index));
                check_field("tick_count", next_due.tick_count,      out_data.tick_count);
                check_field("last",       32'(next_due.last),       32'(out_data.last));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sleep_slot_countdown_timer_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // zero count yields, counter stays put
    task automatic test_zero_count_yield();
        send_timer_request(sleep_request(16'h0000, 31'd0));
        send_timer_request(sleep_request(16'hFFFF, 31'd0));
        settle_outputs();
    endtask

    // ticks on an empty table: counter moves, no result
    task automatic test_tick_empty_table();
        send_timer_request(tick_request());
        send_timer_request(tick_request());
        settle_outputs();
    endtask

    // fill every slot, try two more (table full), then wake all on one tick
    task automatic test_full_table_wake_all();
        for (int i = 0; i < NUM_SLOTS; i++)
            send_timer_request(sleep_request((i % 2) ? 16'hFFFF - 16'(i) : 16'(i), 31'd3));
        send_timer_request(sleep_request(16'h5555, 31'h7FFF_FFFF));
        send_timer_request(sleep_request(16'hAAAA, 31'd1));
        repeat (3) send_timer_request(tick_request());
        settle_outputs();
    endtask

    // staggered expiry and reuse of the lowest freed slot
    task automatic test_staggered_wake();
        send_timer_request(sleep_request(16'h1234, 31'd2));
        send_timer_request(sleep_request(16'h00FF, 31'd1));
        send_timer_request(sleep_request(16'hFF00, 31'd2));
        send_timer_request(tick_request());
        send_timer_request(sleep_request(16'hBEEF, 31'd1));
        send_timer_request(tick_request());
        settle_outputs();
    endtask

    // mixed traffic with both pressure cases
    task automatic test_random_traffic();
        in_t req;
        int  pick;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                source_idle = ($urandom_range(0, 3) != 0);
                sink_idle   = ($urandom_range(0, 3) != 0);
            end
            // result side goes quiet while requests keep coming
            if (n == 60)
                sink_hold_cycles = LONG_HOLD;
            // request side waits for a fully drained block
            if (n == 130)
                settle_outputs();
            pick = $urandom_range(0, 99);
            if (pick < 48)
                req = tick_request();
            else if (pick < 56)
                req = sleep_request(16'($urandom), 31'd0);
            else if (free_slot_total() == 0)
                req = sleep_request(16'($urandom), 31'($urandom));   // full: wide counts, yield
            else
                req = sleep_request(16'($urandom), 31'($urandom_range(1, 12)));
            send_timer_request(req);
        end
        source_idle = 1'b1;
        sink_idle   = 1'b1;
        settle_outputs();
    endtask

    // longest sleep holds its slot for the rest of the run
    task automatic test_longest_sleep();
        send_timer_request(sleep_request(16'hFFFF, 31'h7FFF_FFFF));
        send_timer_request(tick_request());
        send_timer_request(tick_request());
        settle_outputs();
    endtask

    initial
    begin : test_sequence
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_zero_count_yield();
        test_tick_empty_table();
        test_full_table_wake_all();
        test_staggered_wake();
        test_random_traffic();
        test_longest_sleep();

        // let any stray result surface before the verdict
        repeat (SETTLE_TAIL) @(posedge clk);
        if (fault_count == 0 && due_events.size() == 0)
            $display("sleep_slot_countdown_timer_top test passed");
        else
            $display("sleep_slot_countdown_timer_top test failed");
        $finish;
    end

endmodule
